[sv/tdm_pkg.sv]
`default_nettype none
package tdm_pkg;

	// Number of oscillators; the request carries one field set per oscillator.
	localparam int NUM_OSC = 3;
	localparam int OSC_W = $clog2(NUM_OSC);

	// Field widths.
	localparam int TUNE_W = 32;
	localparam int WIDTH_W = 17;
	localparam int GAIN_W = 13;
	localparam int SAMPLE_W = 12;
	localparam int DAC_W = 16;
	localparam int SHAPE_W = 3;
	localparam int PHASE_W = 32;

	// Configuration register map: shapes first, then phase offsets.
	localparam int CFG_DATA_W = 32;
	localparam int NUM_REGS = 2 * NUM_OSC;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int CFG_ADDR_W = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_SHAPE_BASE = '0;
	localparam logic [REG_IDX_W-1:0] REG_OFF_BASE = REG_IDX_W'(NUM_OSC);

	// Wave shape codes.
	typedef logic [SHAPE_W-1:0] shape_t;
	localparam shape_t SHAPE_SINE = 3'd0;
	localparam shape_t SHAPE_TRI = 3'd1;
	localparam shape_t SHAPE_SAW_UP = 3'd2;
	localparam shape_t SHAPE_SAW_DN = 3'd3;
	localparam shape_t SHAPE_SQUARE = 3'd4;
	localparam shape_t SHAPE_NOISE = 3'd5;

	// Sine evaluation constants (Q30 fixed point).
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] SINE_SCALE = 32'd2047;
	localparam logic [63:0] ROUND_HALF = 64'd1 << 29;
	localparam logic [10:0] SINE_AMP_MAX = 11'd2047;
	localparam logic [11:0] SINE_MID = 12'd2048;
	localparam logic [14:0] QUARTER_WAVE = 15'd16384;

	// Constant dividers of the Horner steps: reciprocal, shift and divisor.
	typedef logic [1:0] div_step_t;
	localparam div_step_t DIV_72 = 2'd0;
	localparam div_step_t DIV_42 = 2'd1;
	localparam div_step_t DIV_20 = 2'd2;
	localparam div_step_t DIV_6 = 2'd3;
	localparam logic [31:0] DIV_D0 = 32'd72;
	localparam logic [31:0] DIV_D1 = 32'd42;
	localparam logic [31:0] DIV_D2 = 32'd20;
	localparam logic [31:0] DIV_D3 = 32'd6;
	localparam int DIV_S0 = 38;
	localparam int DIV_S1 = 37;
	localparam int DIV_S2 = 36;
	localparam int DIV_S3 = 34;
	localparam logic [31:0] DIV_M0 = 32'((64'd1 << DIV_S0) / 64'(DIV_D0));
	localparam logic [31:0] DIV_M1 = 32'((64'd1 << DIV_S1) / 64'(DIV_D1));
	localparam logic [31:0] DIV_M2 = 32'((64'd1 << DIV_S2) / 64'(DIV_D2));
	localparam logic [31:0] DIV_M3 = 32'((64'd1 << DIV_S3) / 64'(DIV_D3));

	// Noise generator.
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [12:0] NOISE_MOD = 13'd4095;

	// Output stage.
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
	localparam logic [DAC_W-1:0] DAC_OFFSET = 16'd256;

endpackage
`default_nettype wire

[sv/tdm_ifs.sv]
`default_nettype none
// Sample tick request: tuning words, pulse widths, gains and master gain.
interface tdm_in_if import tdm_pkg::*; ();
	logic valid;
	logic ready;
	logic [TUNE_W-1:0] tune0;
	logic [TUNE_W-1:0] tune1;
	logic [TUNE_W-1:0] tune2;
	logic [WIDTH_W-1:0] width0;
	logic [WIDTH_W-1:0] width1;
	logic [WIDTH_W-1:0] width2;
	logic [GAIN_W-1:0] gain0;
	logic [GAIN_W-1:0] gain1;
	logic [GAIN_W-1:0] gain2;
	logic [GAIN_W-1:0] master_gain;

	modport source (
		output valid, tune0, tune1, tune2, width0, width1, width2,
		output gain0, gain1, gain2, master_gain,
		input ready
	);
	modport sink (
		input valid, tune0, tune1, tune2, width0, width1, width2,
		input gain0, gain1, gain2, master_gain,
		output ready
	);
endinterface

// Mixed sample request.
interface tdm_out_if import tdm_pkg::*; ();
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] mixed_sample;
	logic clipped;
	logic [DAC_W-1:0] dac_code;

	modport source (output valid, mixed_sample, clipped, dac_code, input ready);
	modport sink (input valid, mixed_sample, clipped, dac_code, output ready);
endinterface
`default_nettype wire

[sv/three_osc_dds_mixer_core.sv]
// Each request, from acceptance until the block is ready again, runs an accept step, then per
// oscillator phase, index, select (a sine adds the Horner steps) and gain steps, then the mix.
// The mix is registered into the output register in ST_FIN; a stalled output holds the sequencer.
// One shared 32x32 multiplier, registered, serves all sequencer products in turn.
// Reset (arst_n, asynchronous) clears accumulators, shapes, offsets and seeds the noise.
`default_nettype none
module three_osc_dds_mixer_core import tdm_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tdm_in_if.sink tick,
	tdm_out_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic pready
);

	localparam int SUM_W = $clog2(NUM_OSC * (1 << GAIN_W));

	// Sequencer states.
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_PH = 5'd1;
	localparam logic [4:0] ST_IX = 5'd2;
	localparam logic [4:0] ST_SEL = 5'd3;
	localparam logic [4:0] ST_MX = 5'd4;
	localparam logic [4:0] ST_WX = 5'd5;
	localparam logic [4:0] ST_MXX = 5'd6;
	localparam logic [4:0] ST_WX2 = 5'd7;
	localparam logic [4:0] ST_MD = 5'd8;
	localparam logic [4:0] ST_WD = 5'd9;
	localparam logic [4:0] ST_MT = 5'd10;
	localparam logic [4:0] ST_WT = 5'd11;
	localparam logic [4:0] ST_MS = 5'd12;
	localparam logic [4:0] ST_WS = 5'd13;
	localparam logic [4:0] ST_MA = 5'd14;
	localparam logic [4:0] ST_WA = 5'd15;
	localparam logic [4:0] ST_MG = 5'd16;
	localparam logic [4:0] ST_WG = 5'd17;
	localparam logic [4:0] ST_MM = 5'd18;
	localparam logic [4:0] ST_WM = 5'd19;
	localparam logic [4:0] ST_FIN = 5'd20;

	logic [4:0] state_q;
	logic [OSC_W-1:0] osc_q;
	div_step_t div_idx_q;

	// Configuration and oscillator state.
	shape_t shape_q [NUM_OSC];
	logic [PHASE_W-1:0] off_q [NUM_OSC];
	logic [PHASE_W-1:0] acc_q [NUM_OSC];
	logic [15:0] lfsr_q;

	// Latched request.
	logic [TUNE_W-1:0] tune_q [NUM_OSC];
	logic [WIDTH_W-1:0] width_q [NUM_OSC];
	logic [GAIN_W-1:0] gain_q [NUM_OSC];
	logic [GAIN_W-1:0] master_q;

	// Datapath registers.
	logic [15:0] p16_q;
	logic [14:0] q_q;
	logic [1:0] quad_q;
	logic [31:0] x_q;
	logic [31:0] x2_q;
	logic [31:0] n_q;
	logic [31:0] t_q;
	logic [31:0] s_q;
	logic [SAMPLE_W-1:0] val_q;
	logic [SUM_W-1:0] sum_q;
	logic [63:0] prod_q;
	logic [SAMPLE_W-1:0] mix_q;
	logic clip_q;

	// Output register.
	logic out_v_q;
	logic [SAMPLE_W-1:0] out_mix_q;
	logic out_clip_q;
	logic [DAC_W-1:0] out_dac_q;

	logic [TUNE_W-1:0] tune_in [NUM_OSC];
	logic [WIDTH_W-1:0] width_in [NUM_OSC];
	logic [GAIN_W-1:0] gain_in [NUM_OSC];

	logic accept;
	logic cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic out_free;
	logic last_osc;

	logic [PHASE_W-1:0] phase_sum;
	logic [TABLE_ADDR_BITS-1:0] tab_idx;
	logic [15:0] lfsr_nxt;
	logic [12:0] noise_fold;
	logic [SAMPLE_W-1:0] noise_val;
	logic [SAMPLE_W-1:0] wave_val;
	logic [14:0] q_mir;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] div_est;
	logic [31:0] div_d;
	logic [31:0] div_qd;
	logic [31:0] div_rem;
	logic [31:0] div_quo;
	logic [63:0] amp_full;
	logic [10:0] amp;
	logic [SAMPLE_W-1:0] sine_val;
	logic [63:0] mix_full;
	logic [DAC_W-1:0] dac_m;

	// Unpack the request fields into per-oscillator arrays.
	always_comb begin
		tune_in[0] = tick.tune0;
		tune_in[1] = tick.tune1;
		tune_in[2] = tick.tune2;
		width_in[0] = tick.width0;
		width_in[1] = tick.width1;
		width_in[2] = tick.width2;
		gain_in[0] = tick.gain0;
		gain_in[1] = tick.gain1;
		gain_in[2] = tick.gain2;
	end

	assign tick.ready = (state_q == ST_IDLE);
	assign accept = tick.valid && tick.ready;
	assign out_free = !out_v_q || result.ready;
	assign last_osc = (osc_q == OSC_W'(NUM_OSC - 1));

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];

	always_comb begin
		prdata = '0;
		for (int k = 0; k < NUM_OSC; k++) begin
			if (reg_idx == REG_IDX_W'(REG_SHAPE_BASE + k)) begin
				prdata = CFG_DATA_W'(shape_q[k]);
			end
			if (reg_idx == REG_IDX_W'(REG_OFF_BASE + k)) begin
				prdata = CFG_DATA_W'(off_q[k]);
			end
		end
	end

	// Table index and the 16-bit phase it stands for.
	assign phase_sum = acc_q[osc_q] + off_q[osc_q];
	assign tab_idx = phase_sum[PHASE_W-1 -: TABLE_ADDR_BITS];

	// Noise: one Galois step, then fold modulo 4095 using 4096 = 1 (mod 4095).
	assign lfsr_nxt = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
	assign noise_fold = 13'(lfsr_nxt[15:12]) + 13'(lfsr_nxt[11:0]);
	assign noise_val = (noise_fold >= NOISE_MOD) ? 12'(noise_fold - NOISE_MOD)
		: noise_fold[11:0];

	// Shapes that need no multiplier.
	always_comb begin
		case (shape_q[osc_q])
			SHAPE_TRI: begin
				wave_val = p16_q[15] ? ~p16_q[14:3] : p16_q[14:3];
			end
			SHAPE_SAW_UP: begin
				wave_val = p16_q[15:4];
			end
			SHAPE_SAW_DN: begin
				wave_val = ~p16_q[15:4];
			end
			SHAPE_SQUARE: begin
				wave_val = (WIDTH_W'(p16_q) < width_q[osc_q]) ? SAMPLE_MAX : '0;
			end
			SHAPE_NOISE: begin
				wave_val = noise_val;
			end
			default: begin
				wave_val = '0;
			end
		endcase
	end

	// Quarter-wave mirror for the sine.
	assign q_mir = p16_q[14] ? 15'(QUARTER_WAVE - 15'(p16_q[13:0])) : 15'(p16_q[13:0]);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_MX: begin
				mul_a = 32'(q_q);
				mul_b = HALF_PI_Q30;
			end
			ST_MXX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_MD: begin
				mul_a = n_q;
				case (div_idx_q)
					DIV_72: mul_b = DIV_M0;
					DIV_42: mul_b = DIV_M1;
					DIV_20: mul_b = DIV_M2;
					default: mul_b = DIV_M3;
				endcase
			end
			ST_MT: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
			ST_MS: begin
				mul_a = x_q;
				mul_b = t_q;
			end
			ST_MA: begin
				mul_a = s_q;
				mul_b = SINE_SCALE;
			end
			ST_MG: begin
				mul_a = 32'(val_q);
				mul_b = 32'(gain_q[osc_q]);
			end
			ST_MM: begin
				mul_a = 32'(sum_q);
				mul_b = 32'(master_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Constant division: reciprocal estimate is low by at most one.
	always_comb begin
		case (div_idx_q)
			DIV_72: begin
				div_est = 32'(prod_q >> DIV_S0);
				div_d = DIV_D0;
				div_qd = div_est * DIV_D0;
			end
			DIV_42: begin
				div_est = 32'(prod_q >> DIV_S1);
				div_d = DIV_D1;
				div_qd = div_est * DIV_D1;
			end
			DIV_20: begin
				div_est = 32'(prod_q >> DIV_S2);
				div_d = DIV_D2;
				div_qd = div_est * DIV_D2;
			end
			default: begin
				div_est = 32'(prod_q >> DIV_S3);
				div_d = DIV_D3;
				div_qd = div_est * DIV_D3;
			end
		endcase
		div_rem = n_q - div_qd;
		div_quo = div_est + 32'(div_rem >= div_d);
	end

	// Sine amplitude: round, clamp and place around mid-scale.
	assign amp_full = (prod_q + ROUND_HALF) >> 30;
	assign amp = (amp_full > 64'(SINE_AMP_MAX)) ? SINE_AMP_MAX : amp_full[10:0];
	assign sine_val = quad_q[1] ? 12'(SINE_MID - 12'(amp)) : 12'(SINE_MID + 12'(amp));

	// Master scaling and DAC code.
	assign mix_full = prod_q >> 11;
	assign dac_m = DAC_W'(mix_q) + DAC_OFFSET;

	// Sequencer, oscillator state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			osc_q <= '0;
			div_idx_q <= DIV_72;
			lfsr_q <= LFSR_SEED;
			for (int k = 0; k < NUM_OSC; k++) begin
				shape_q[k] <= SHAPE_SINE;
				off_q[k] <= '0;
				acc_q[k] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				for (int k = 0; k < NUM_OSC; k++) begin
					if (reg_idx == REG_IDX_W'(REG_SHAPE_BASE + k)) begin
						shape_q[k] <= pwdata[SHAPE_W-1:0];
					end
					if (reg_idx == REG_IDX_W'(REG_OFF_BASE + k)) begin
						off_q[k] <= pwdata[PHASE_W-1:0];
					end
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						osc_q <= '0;
						state_q <= ST_PH;
					end
				end
				ST_PH: begin
					acc_q[osc_q] <= acc_q[osc_q] + tune_q[osc_q];
					state_q <= ST_IX;
				end
				ST_IX: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (shape_q[osc_q] == SHAPE_SINE) begin
						state_q <= ST_MX;
					end else begin
						if (shape_q[osc_q] == SHAPE_NOISE) begin
							lfsr_q <= lfsr_nxt;
						end
						state_q <= ST_MG;
					end
				end
				ST_MX: state_q <= ST_WX;
				ST_WX: state_q <= ST_MXX;
				ST_MXX: state_q <= ST_WX2;
				ST_WX2: begin
					div_idx_q <= DIV_72;
					state_q <= ST_MD;
				end
				ST_MD: state_q <= ST_WD;
				ST_WD: begin
					div_idx_q <= div_idx_q + 2'd1;
					state_q <= (div_idx_q == DIV_6) ? ST_MS : ST_MT;
				end
				ST_MT: state_q <= ST_WT;
				ST_WT: state_q <= ST_MD;
				ST_MS: state_q <= ST_WS;
				ST_WS: state_q <= ST_MA;
				ST_MA: state_q <= ST_WA;
				ST_WA: state_q <= ST_MG;
				ST_MG: state_q <= ST_WG;
				ST_WG: begin
					if (last_osc) begin
						state_q <= ST_MM;
					end else begin
						osc_q <= osc_q + OSC_W'(1);
						state_q <= ST_PH;
					end
				end
				ST_MM: state_q <= ST_WM;
				ST_WM: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers and the shared multiplier.
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tune_q <= tune_in;
					width_q <= width_in;
					gain_q <= gain_in;
					master_q <= tick.master_gain;
					sum_q <= '0;
				end
			end
			ST_IX: begin
				p16_q <= 16'(tab_idx) << (16 - TABLE_ADDR_BITS);
			end
			ST_SEL: begin
				q_q <= q_mir;
				quad_q <= p16_q[15:14];
				val_q <= wave_val;
			end
			ST_WX: x_q <= 32'(prod_q >> 14);
			ST_WX2: begin
				x2_q <= 32'(prod_q >> 30);
				n_q <= 32'(prod_q >> 30);
			end
			ST_WD: t_q <= Q30_ONE - div_quo;
			ST_WT: n_q <= 32'(prod_q >> 30);
			ST_WS: s_q <= 32'(prod_q >> 30);
			ST_WA: val_q <= sine_val;
			ST_WG: sum_q <= sum_q + SUM_W'(prod_q >> 12);
			ST_WM: begin
				clip_q <= (mix_full > 64'(SAMPLE_MAX));
				mix_q <= (mix_full > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : mix_full[SAMPLE_W-1:0];
			end
			ST_FIN: begin
				if (out_free) begin
					out_mix_q <= mix_q;
					out_clip_q <= clip_q;
					out_dac_q <= (dac_m << 4) - (dac_m << 1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign result.valid = out_v_q;
	assign result.mixed_sample = out_mix_q;
	assign result.clipped = out_clip_q;
	assign result.dac_code = out_dac_q;

	// An accepted request always starts at the first oscillator.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PH && osc_q == '0))
		else $error("accepted request did not start the oscillator sweep");

	// The reciprocal estimate must be at most one below the true quotient.
	a_div_correction: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WD) |-> (div_rem < (div_d << 1)))
		else $error("constant divider estimate off by more than one");

	// A clipped result sits at full scale.
	a_clip_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clipped) |-> (result.mixed_sample == SAMPLE_MAX))
		else $error("clipped result is not at full scale");

endmodule
`default_nettype wire

[tb/sv/three_osc_dds_mixer_core_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module three_osc_dds_mixer_core_tb import tdm_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 100;
	localparam int REG_STEP = 4;

	// Shape codes that the package leaves unnamed; both must give silence.
	localparam shape_t SHAPE_UNUSED6 = 3'd6;
	localparam shape_t SHAPE_UNUSED7 = 3'd7;

	// One sample tick request, one field set per oscillator.
	typedef struct packed {
		logic [NUM_OSC-1:0][TUNE_W-1:0] tune;
		logic [NUM_OSC-1:0][WIDTH_W-1:0] width;
		logic [NUM_OSC-1:0][GAIN_W-1:0] gain;
		logic [GAIN_W-1:0] master_gain;
	} tick_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mixed_sample;
		logic clipped;
		logic [DAC_W-1:0] dac_code;
	} mix_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	tdm_in_if tick_if();
	tdm_out_if result_if();

	// Shadow of the synthesiser: registers, accumulators and noise generator.
	shape_t osc_shape [NUM_OSC];
	logic [PHASE_W-1:0] osc_offset [NUM_OSC];
	logic [PHASE_W-1:0] osc_phase [NUM_OSC];
	logic [15:0] noise_reg;

	mix_result_t expected_samples [$];
	int send_idle_pct;
	int recv_idle_pct;
	int failures;
	int cycle_count;

	three_osc_dds_mixer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_if),
		.result(result_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Quarter-wave sine by truncating Horner steps, mirrored over the full cycle.
	function automatic logic [SAMPLE_W-1:0] sine_value(input logic [15:0] p);
		logic [63:0] q, x, x2, t, s, a;
		q = 64'(p[13:0]);
		if (p[14])
			q = 64'd16384 - q;
		x = (q * 64'(HALF_PI_Q30)) / 64'd16384;
		x2 = (x * x) >> 30;
		t = 64'(Q30_ONE) - x2 / 64'd72;
		t = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd42;
		t = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd20;
		t = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		a = (s * 64'd2047 + (64'd1 << 29)) >> 30;
		if (a > 64'd2047)
			a = 64'd2047;
		return p[15] ? SAMPLE_W'(64'd2048 - a) : SAMPLE_W'(64'd2048 + a);
	endfunction

	// Advances the shadow by one tick and works out the mixed sample it gives.
	function automatic mix_result_t synth_sample(input tick_t req);
		logic [63:0] sum, mix;
		logic [PHASE_W-1:0] pos;
		logic [15:0] p;
		logic [SAMPLE_W-1:0] v;
		logic lsb;
		mix_result_t r;
		sum = '0;
		for (int k = 0; k < NUM_OSC; k++) begin
			osc_phase[k] = osc_phase[k] + req.tune[k];
			pos = osc_phase[k] + osc_offset[k];
			p = pos[31:16];
			case (osc_shape[k])
				SHAPE_SINE: v = sine_value(p);
				SHAPE_TRI: v = p[15] ? SAMPLE_W'((16'hFFFF - p) >> 3) : SAMPLE_W'(p >> 3);
				SHAPE_SAW_UP: v = p[15:4];
				SHAPE_SAW_DN: v = 12'd4095 - p[15:4];
				SHAPE_SQUARE: v = ({1'b0, p} < req.width[k]) ? 12'd4095 : 12'd0;
				SHAPE_NOISE: begin
					lsb = noise_reg[0];
					noise_reg = noise_reg >> 1;
					if (lsb)
						noise_reg = noise_reg ^ LFSR_TAPS;
					v = SAMPLE_W'(noise_reg % 16'd4095);
				end
				default: v = '0;
			endcase
			sum = sum + ((64'(v) * 64'(req.gain[k])) >> 12);
		end
		mix = (sum * 64'(req.master_gain)) >> 11;
		r.clipped = (mix > 64'd4095);
		if (r.clipped)
			mix = 64'd4095;
		r.mixed_sample = mix[SAMPLE_W-1:0];
		r.dac_code = DAC_W'((mix + 64'(DAC_OFFSET)) * 64'd14);
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] shadow_reg(input int idx);
		if (idx < NUM_OSC)
			return CFG_DATA_W'(osc_shape[idx]);
		return osc_offset[idx - NUM_OSC];
	endfunction

	function automatic tick_t uniform_tick(input logic [TUNE_W-1:0] tune,
			input logic [WIDTH_W-1:0] width, input logic [GAIN_W-1:0] gain,
			input logic [GAIN_W-1:0] master);
		tick_t t;
		for (int k = 0; k < NUM_OSC; k++) begin
			t.tune[k] = tune;
			t.width[k] = width;
			t.gain[k] = gain;
		end
		t.master_gain = master;
		return t;
	endfunction

	// Random request: mostly ordinary values, with extremes and out-of-range fields.
	function automatic tick_t random_tick();
		tick_t t;
		for (int k = 0; k < NUM_OSC; k++) begin
			case ($urandom_range(9))
				0: t.tune[k] = '0;
				1: t.tune[k] = '1;
				2, 3, 4: t.tune[k] = $urandom_range(32'h00FF_FFFF, 0);
				default: t.tune[k] = $urandom;
			endcase
			case ($urandom_range(9))
				0: t.width[k] = '0;
				1: t.width[k] = 17'd65536;
				2: t.width[k] = WIDTH_W'($urandom_range(131071, 65537));
				default: t.width[k] = WIDTH_W'($urandom_range(65535, 0));
			endcase
			case ($urandom_range(9))
				0: t.gain[k] = '0;
				1: t.gain[k] = 13'd4096;
				2: t.gain[k] = GAIN_W'($urandom_range(8191, 4097));
				default: t.gain[k] = GAIN_W'($urandom_range(4096, 0));
			endcase
		end
		case ($urandom_range(9))
			0: t.master_gain = '0;
			1: t.master_gain = 13'd4096;
			2: t.master_gain = GAIN_W'($urandom_range(8191, 4097));
			3, 4: t.master_gain = GAIN_W'($urandom_range(1500, 0));
			default: t.master_gain = GAIN_W'($urandom_range(4096, 0));
		endcase
		return t;
	endfunction

	// Offers one request, idling at random first, and records its expected sample.
	task automatic send_tick(input tick_t req);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_if.valid = 1'b0;
			@(negedge clk);
		end
		tick_if.valid = 1'b1;
		tick_if.tune0 = req.tune[0];
		tick_if.tune1 = req.tune[1];
		tick_if.tune2 = req.tune[2];
		tick_if.width0 = req.width[0];
		tick_if.width1 = req.width[1];
		tick_if.width2 = req.width[2];
		tick_if.gain0 = req.gain[0];
		tick_if.gain1 = req.gain[1];
		tick_if.gain2 = req.gain[2];
		tick_if.master_gain = req.master_gain;
		do
			@(posedge clk);
		while (!tick_if.ready);
		expected_samples.push_back(synth_sample(req));
	endtask

	// Holds back further requests until every expected sample has arrived.
	task automatic drain_results();
		@(negedge clk);
		tick_if.valid = 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = CFG_ADDR_W'(idx * REG_STEP);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx < NUM_OSC)
			osc_shape[idx] = value[SHAPE_W-1:0];
		else
			osc_offset[idx - NUM_OSC] = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_reg(input int idx);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = CFG_ADDR_W'(idx * REG_STEP);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== shadow_reg(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, shadow_reg(idx), prdata);
			failures++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Reprograms all oscillators once the block is idle, then reads them back.
	task automatic apply_config(input shape_t s0, input shape_t s1, input shape_t s2,
			input logic [PHASE_W-1:0] o0, input logic [PHASE_W-1:0] o1,
			input logic [PHASE_W-1:0] o2);
		drain_results();
		write_reg(int'(REG_SHAPE_BASE) + 0, CFG_DATA_W'(s0));
		write_reg(int'(REG_SHAPE_BASE) + 1, CFG_DATA_W'(s1));
		write_reg(int'(REG_SHAPE_BASE) + 2, CFG_DATA_W'(s2));
		write_reg(int'(REG_OFF_BASE) + 0, o0);
		write_reg(int'(REG_OFF_BASE) + 1, o1);
		write_reg(int'(REG_OFF_BASE) + 2, o2);
		for (int i = 0; i < NUM_REGS; i++)
			check_reg(i);
	endtask

	function automatic logic [PHASE_W-1:0] random_offset();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Reset values, then sine across all quadrants and a tick with every field at its maximum.
	task automatic test_reset_sine();
		for (int i = 0; i < NUM_REGS; i++)
			check_reg(i);
		send_tick(uniform_tick('0, '0, '0, '0));
		repeat (3)
			send_tick(uniform_tick(32'h4000_0000, '0, 13'd4096, 13'd4096));
		send_tick(uniform_tick('1, 17'h1FFFF, 13'h1FFF, 13'h1FFF));
		drain_results();
	endtask

	task automatic test_ramp_shapes();
		apply_config(SHAPE_TRI, SHAPE_SAW_UP, SHAPE_SAW_DN,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		send_tick(uniform_tick(32'h0123_4567, 17'd100, 13'd4096, 13'd2048));
		send_tick(uniform_tick(32'h8000_0000, 17'd100, 13'd4096, 13'd4096));
		send_tick(uniform_tick(32'h3FFF_FFFF, 17'd100, 13'd2000, 13'd1000));
		send_tick(uniform_tick('0, 17'd100, '0, 13'h1FFF));
	endtask

	// Pulse widths from zero to beyond the full index range, beside noise.
	task automatic test_square_noise();
		apply_config(SHAPE_SQUARE, SHAPE_NOISE, SHAPE_UNUSED6, '0, '0, '0);
		send_tick(uniform_tick(32'h1000_0000, '0, 13'd4096, 13'd1024));
		send_tick(uniform_tick(32'h1000_0000, 17'd32768, 13'd4096, 13'd1024));
		send_tick(uniform_tick(32'h1000_0000, 17'd65536, 13'h1FFF, 13'd1024));
		send_tick(uniform_tick(32'h1000_0000, 17'h1FFFF, 13'd4096, 13'd1024));
	endtask

	// Unused code beside two noise oscillators, which step the generator twice.
	task automatic test_unused_noise();
		apply_config(SHAPE_UNUSED7, SHAPE_NOISE, SHAPE_NOISE, '1, '1, '1);
		send_tick(uniform_tick(32'h0800_0000, 17'd65535, 13'd4096, 13'd1365));
		send_tick(uniform_tick(32'h0800_0000, 17'd65535, 13'd4096, 13'd4096));
		send_tick(uniform_tick(32'h0800_0000, 17'd65535, 13'd4096, 13'd700));
		send_tick(uniform_tick(32'h0800_0000, 17'd65535, 13'd4096, '0));
	endtask

	// Random requests under one idling pattern, reconfigured every so often.
	task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				apply_config(shape_t'($urandom_range(7)), shape_t'($urandom_range(7)),
					shape_t'($urandom_range(7)), random_offset(), random_offset(),
					random_offset());
			else if ($urandom_range(49) == 0)
				drain_results();
			send_tick(random_tick());
		end
	endtask

	// The sink stalls at random, changing only at the falling edge.
	always @(negedge clk)
		result_if.ready = ($urandom_range(99) >= recv_idle_pct);

	// Each accepted sample is compared with the oldest expectation.
	always @(posedge clk) begin : check_samples
		mix_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample with no request outstanding: %0d", result_if.mixed_sample);
				failures++;
			end else begin
				want = expected_samples.pop_front();
				if (result_if.mixed_sample !== want.mixed_sample) begin
					$error("mixed_sample: expected %0d, got %0d",
						want.mixed_sample, result_if.mixed_sample);
					failures++;
				end
				if (result_if.clipped !== want.clipped) begin
					$error("clipped: expected %0d, got %0d", want.clipped, result_if.clipped);
					failures++;
				end
				if (result_if.dac_code !== want.dac_code) begin
					$error("dac_code: expected %0d, got %0d", want.dac_code, result_if.dac_code);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		failures = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_if.valid = 1'b0;
		tick_if.tune0 = '0;
		tick_if.tune1 = '0;
		tick_if.tune2 = '0;
		tick_if.width0 = '0;
		tick_if.width1 = '0;
		tick_if.width2 = '0;
		tick_if.gain0 = '0;
		tick_if.gain1 = '0;
		tick_if.gain2 = '0;
		tick_if.master_gain = '0;
		result_if.ready = 1'b0;
		for (int k = 0; k < NUM_OSC; k++) begin
			osc_shape[k] = SHAPE_SINE;
			osc_offset[k] = '0;
			osc_phase[k] = '0;
		end
		noise_reg = LFSR_SEED;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_sine();
		test_ramp_shapes();
		test_square_noise();
		test_unused_noise();
		test_random_phase(480, 18, 58);
		test_random_phase(480, 58, 18);
		test_random_phase(490, 0, 0);

		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
